// File: design/emi_pkg.sv
// ----------------------------------------------------------------------------
// emi_pkg
// Shared types, codes and a helper function of the motion integrator.
// ----------------------------------------------------------------------------
package emi_pkg;

  localparam int STEP_FRAC = 16;
  localparam int DRAG_FRAC = 16;

  localparam logic CMD_ADD_FORCE = 1'b0;
  localparam logic CMD_UPDATE    = 1'b1;

  localparam logic [2:0] REG_FORWARD_SPEED = 3'd0;
  localparam logic [2:0] REG_STATIC_MODE   = 3'd1;
  localparam logic [2:0] REG_MASS          = 3'd2;
  localparam logic [2:0] REG_DRAG          = 3'd3;
  localparam logic [2:0] REG_MAX_SPEED     = 3'd4;
  localparam logic [2:0] REG_SCREEN_WRAP   = 3'd5;

  localparam logic [16:0] DRAG_RESET = 17'd64291;

  typedef logic [4:0] emi_op_t;

  localparam emi_op_t OP_NOP      = 5'd0;
  localparam emi_op_t OP_ACCEPT   = 5'd1;
  localparam emi_op_t OP_THR_M1   = 5'd2;
  localparam emi_op_t OP_THR_W1   = 5'd3;
  localparam emi_op_t OP_THR_M2   = 5'd4;
  localparam emi_op_t OP_THR_W2   = 5'd5;
  localparam emi_op_t OP_DIV_ACC  = 5'd6;
  localparam emi_op_t OP_ACC_W    = 5'd7;
  localparam emi_op_t OP_VEL_M    = 5'd8;
  localparam emi_op_t OP_VEL_W    = 5'd9;
  localparam emi_op_t OP_DRAG_M   = 5'd10;
  localparam emi_op_t OP_DRAG_W   = 5'd11;
  localparam emi_op_t OP_SQ_M     = 5'd12;
  localparam emi_op_t OP_SQ_W     = 5'd13;
  localparam emi_op_t OP_MS_M     = 5'd14;
  localparam emi_op_t OP_SQRT     = 5'd15;
  localparam emi_op_t OP_CL_M     = 5'd16;
  localparam emi_op_t OP_DIV_CL   = 5'd17;
  localparam emi_op_t OP_CL_W     = 5'd18;
  localparam emi_op_t OP_POS_M    = 5'd19;
  localparam emi_op_t OP_POS_W    = 5'd20;
  localparam emi_op_t OP_WRAP     = 5'd21;
  localparam emi_op_t OP_LOAD_OUT = 5'd22;

  typedef struct packed {
    emi_op_t    op;
    logic [1:0] idx;
  } emi_cmd_t;

  typedef struct packed {
    logic static_mode;
    logic thrust_on;
    logic div_busy;
    logic sqrt_busy;
    logic clamp;
    logic out_free;
  } emi_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// File: design/emi_if.sv
// ----------------------------------------------------------------------------
// emi request and result channels
// Valid/ready channels carrying one request and one result item.
// ----------------------------------------------------------------------------
interface emi_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic [15:0]        time_step;

  modport source (output valid, command, vec_x, vec_y, vec_z, time_step, input ready);
  modport sink (input valid, command, vec_x, vec_y, vec_z, time_step, output ready);
endinterface

interface emi_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

// File: design/emi_div.sv
// ----------------------------------------------------------------------------
// emi_div
// Radix-2 restoring divider, signed dividend by unsigned divisor, truncating.
// ----------------------------------------------------------------------------
module emi_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [31:0]        den,
  output logic               busy,
  output logic signed [64:0] quot
);

  logic [63:0] dvd;
  logic [32:0] rem;
  logic [31:0] dsr;
  logic        neg;
  logic [5:0]  cnt;
  logic [32:0] shifted;
  logic        fits;

  assign shifted = {rem[31:0], dvd[63]};
  assign fits    = shifted >= {1'b0, dsr};
  assign quot    = neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[63];
      dvd <= num[63] ? 64'(-num) : 64'(num);
      dsr <= den;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? (shifted - {1'b0, dsr}) : shifted;
      dvd <= {dvd[62:0], fits};
    end
  end

endmodule

// File: design/emi_sqrt.sv
// ----------------------------------------------------------------------------
// emi_sqrt
// Digit-by-digit integer square root, floor of the root, two bits a cycle.
// ----------------------------------------------------------------------------
module emi_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] src;
  logic [34:0] rem;
  logic [4:0]  cnt;
  logic [34:0] part;
  logic [34:0] trial;
  logic        fits;

  assign part  = {rem[32:0], src[63:62]};
  assign trial = {1'b0, root, 2'b01};
  assign fits  = part >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      src  <= rad;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      src  <= {src[61:0], 2'b00};
      rem  <= fits ? (part - trial) : part;
      root <= {root[30:0], fits};
    end
  end

endmodule

// File: design/emi_datapath.sv
// ----------------------------------------------------------------------------
// emi_datapath
// Body state, settings, shared multiplier, divider, square root and output.
// ----------------------------------------------------------------------------
module emi_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  emi_pkg::emi_cmd_t  cmd,
  output emi_pkg::emi_sts_t  sts,
  input  logic               req_command,
  input  logic signed [31:0] req_vec_x,
  input  logic signed [31:0] req_vec_y,
  input  logic signed [31:0] req_vec_z,
  input  logic [15:0]        req_time_step,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data,
  emi_rsp_if.source          rsp
);
  import emi_pkg::*;

  localparam logic signed [65:0] X_LIM = 66'sd512 <<< FRAC_BITS;
  localparam logic signed [65:0] Y_LIM = 66'sd384 <<< FRAC_BITS;
  localparam logic signed [31:0] X_HI  = sat32(66'sd510 <<< FRAC_BITS);
  localparam logic signed [31:0] X_LO  = sat32(-(66'sd510 <<< FRAC_BITS));
  localparam logic signed [31:0] Y_HI  = sat32(66'sd382 <<< FRAC_BITS);
  localparam logic signed [31:0] Y_LO  = sat32(-(66'sd382 <<< FRAC_BITS));

  logic signed [31:0] forward_speed;
  logic               static_mode;
  logic [30:0]        mass;
  logic [16:0]        drag;
  logic [30:0]        max_speed;
  logic               screen_wrap;

  logic signed [31:0] force_sum [3];
  logic signed [31:0] velocity [3];
  logic signed [31:0] position [3];
  logic signed [31:0] vec [3];
  logic [15:0]        step;
  logic signed [31:0] tmp;
  logic signed [63:0] prod;
  logic [63:0]        s2;

  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] full;
  logic signed [63:0] prod_sh;
  logic signed [63:0] prod_fr;

  logic               div_start;
  logic signed [63:0] div_num;
  logic [31:0]        div_den;
  logic               div_busy;
  logic signed [64:0] quot;
  logic               sqrt_start;
  logic               sqrt_busy;
  logic [31:0]        root;
  logic               out_valid;

  assign full    = ma * mb;
  assign prod_sh = prod >>> STEP_FRAC;
  assign prod_fr = prod >>> FRAC_BITS;

  always_comb begin
    ma = 33'(velocity[cmd.idx]);
    mb = 33'(velocity[cmd.idx]);
    unique case (cmd.op)
      OP_THR_M1: begin
        ma = 33'(vec[cmd.idx]);
        mb = 33'(forward_speed);
      end
      OP_THR_M2, OP_VEL_M: begin
        ma = 33'(tmp);
        mb = $signed({17'b0, step});
      end
      OP_DRAG_M: mb = $signed({16'b0, drag});
      OP_MS_M: begin
        ma = $signed({2'b0, max_speed});
        mb = $signed({2'b0, max_speed});
      end
      OP_CL_M: mb = $signed({2'b0, max_speed});
      OP_POS_M: mb = $signed({17'b0, step});
      default: begin
      end
    endcase
  end

  assign div_start  = (cmd.op == OP_DIV_ACC) || (cmd.op == OP_DIV_CL);
  assign div_num    = (cmd.op == OP_DIV_ACC) ? (64'(force_sum[cmd.idx]) <<< FRAC_BITS) : prod;
  assign div_den    = (cmd.op == OP_DIV_ACC) ? ((mass == '0) ? 32'd1 : {1'b0, mass}) : root;
  assign sqrt_start = cmd.op == OP_SQRT;

  emi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (quot)
  );

  emi_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (s2),
    .busy  (sqrt_busy),
    .root  (root)
  );

  assign sts.static_mode = static_mode;
  assign sts.thrust_on   = !forward_speed[31] && (forward_speed != '0);
  assign sts.div_busy    = div_busy;
  assign sts.sqrt_busy   = sqrt_busy;
  assign sts.clamp       = (s2 != '0) && (s2 >= 64'(prod));
  assign sts.out_free    = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_speed <= '0;
      static_mode   <= 1'b0;
      mass          <= 31'(1) << FRAC_BITS;
      drag          <= DRAG_RESET;
      max_speed     <= '0;
      screen_wrap   <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FORWARD_SPEED: forward_speed <= wr_data;
        REG_STATIC_MODE:   static_mode   <= wr_data[0];
        REG_MASS:          mass          <= wr_data[30:0];
        REG_DRAG:          drag          <= wr_data[16:0];
        REG_MAX_SPEED:     max_speed     <= wr_data[30:0];
        REG_SCREEN_WRAP:   screen_wrap   <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        force_sum[i] <= '0;
        velocity[i]  <= '0;
        position[i]  <= '0;
      end
    end else begin
      unique case (cmd.op)
        OP_ACCEPT: begin
          if (req_command == CMD_ADD_FORCE) begin
            force_sum[0] <= sat32(66'(force_sum[0]) + 66'(req_vec_x));
            force_sum[1] <= sat32(66'(force_sum[1]) + 66'(req_vec_y));
            force_sum[2] <= sat32(66'(force_sum[2]) + 66'(req_vec_z));
          end
        end
        OP_THR_W2: force_sum[cmd.idx] <=
            sat32(66'(force_sum[cmd.idx]) + 66'(sat32(66'(prod_sh))));
        OP_ACC_W:  force_sum[cmd.idx] <= '0;
        OP_VEL_W:  velocity[cmd.idx] <= sat32(66'(velocity[cmd.idx]) + 66'(prod_sh));
        OP_DRAG_W: velocity[cmd.idx] <= sat32(66'(prod_sh));
        OP_CL_W:   velocity[cmd.idx] <= sat32(66'(quot));
        OP_POS_W:  position[cmd.idx] <= sat32(66'(position[cmd.idx]) + 66'(prod_sh));
        OP_WRAP: begin
          if (screen_wrap) begin
            if (66'(position[0]) < -X_LIM) begin
              position[0] <= X_HI;
            end else if (66'(position[0]) > X_LIM) begin
              position[0] <= X_LO;
            end
            if (66'(position[1]) < -Y_LIM) begin
              position[1] <= Y_HI;
            end else if (66'(position[1]) > Y_LIM) begin
              position[1] <= Y_LO;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        vec[0] <= req_vec_x;
        vec[1] <= req_vec_y;
        vec[2] <= req_vec_z;
        step   <= req_time_step;
        s2     <= '0;
      end
      OP_THR_M1, OP_THR_M2, OP_VEL_M, OP_DRAG_M, OP_SQ_M, OP_MS_M, OP_CL_M, OP_POS_M:
        prod <= full[63:0];
      OP_THR_W1: tmp <= sat32(66'(prod_fr));
      OP_ACC_W:  tmp <= sat32(66'(quot));
      OP_SQ_W:   s2  <= s2 + 64'(prod);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_LOAD_OUT) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_OUT) begin
      rsp.pos_x <= position[0];
      rsp.pos_y <= position[1];
      rsp.pos_z <= position[2];
      rsp.vel_x <= velocity[0];
      rsp.vel_y <= velocity[1];
      rsp.vel_z <= velocity[2];
    end
  end

  assign rsp.valid = out_valid;

endmodule

// File: design/emi_ctrl.sv
// ----------------------------------------------------------------------------
// emi_ctrl
// Sequencer that steps the datapath through one update, component by component.
// ----------------------------------------------------------------------------
module emi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_command,
  output logic              req_ready,
  output emi_pkg::emi_cmd_t cmd,
  input  emi_pkg::emi_sts_t sts
);
  import emi_pkg::*;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_THR_M1    = 5'd1;
  localparam logic [4:0] S_THR_W1    = 5'd2;
  localparam logic [4:0] S_THR_M2    = 5'd3;
  localparam logic [4:0] S_THR_W2    = 5'd4;
  localparam logic [4:0] S_DIV_GO    = 5'd5;
  localparam logic [4:0] S_DIV_WAIT  = 5'd6;
  localparam logic [4:0] S_ACC_W     = 5'd7;
  localparam logic [4:0] S_VEL_M     = 5'd8;
  localparam logic [4:0] S_VEL_W     = 5'd9;
  localparam logic [4:0] S_DRAG_M    = 5'd10;
  localparam logic [4:0] S_DRAG_W    = 5'd11;
  localparam logic [4:0] S_SQ_M      = 5'd12;
  localparam logic [4:0] S_SQ_W      = 5'd13;
  localparam logic [4:0] S_MS_M      = 5'd14;
  localparam logic [4:0] S_CMP       = 5'd15;
  localparam logic [4:0] S_SQRT_GO   = 5'd16;
  localparam logic [4:0] S_SQRT_WAIT = 5'd17;
  localparam logic [4:0] S_CL_M      = 5'd18;
  localparam logic [4:0] S_CL_GO     = 5'd19;
  localparam logic [4:0] S_CL_WAIT   = 5'd20;
  localparam logic [4:0] S_CL_W      = 5'd21;
  localparam logic [4:0] S_POS_M     = 5'd22;
  localparam logic [4:0] S_POS_W     = 5'd23;
  localparam logic [4:0] S_WRAP      = 5'd24;
  localparam logic [4:0] S_DONE      = 5'd25;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [1:0] idx;
  logic [1:0] idx_next;
  logic       last;

  assign last      = idx == 2'd2;
  assign req_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd.op     = OP_NOP;
    cmd.idx    = idx;
    unique case (state)
      S_IDLE: begin
        idx_next = 2'd0;
        if (req_valid) begin
          cmd.op = OP_ACCEPT;
          if (req_command == CMD_UPDATE) begin
            if (sts.static_mode) begin
              state_next = S_DONE;
            end else if (sts.thrust_on) begin
              state_next = S_THR_M1;
            end else begin
              state_next = S_DIV_GO;
            end
          end
        end
      end
      S_THR_M1: begin
        cmd.op     = OP_THR_M1;
        state_next = S_THR_W1;
      end
      S_THR_W1: begin
        cmd.op     = OP_THR_W1;
        state_next = S_THR_M2;
      end
      S_THR_M2: begin
        cmd.op     = OP_THR_M2;
        state_next = S_THR_W2;
      end
      S_THR_W2: begin
        cmd.op     = OP_THR_W2;
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.op     = OP_DIV_ACC;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!sts.div_busy) begin
          state_next = S_ACC_W;
        end
      end
      S_ACC_W: begin
        cmd.op     = OP_ACC_W;
        state_next = S_VEL_M;
      end
      S_VEL_M: begin
        cmd.op     = OP_VEL_M;
        state_next = S_VEL_W;
      end
      S_VEL_W: begin
        cmd.op     = OP_VEL_W;
        state_next = S_DRAG_M;
      end
      S_DRAG_M: begin
        cmd.op     = OP_DRAG_M;
        state_next = S_DRAG_W;
      end
      S_DRAG_W: begin
        cmd.op     = OP_DRAG_W;
        state_next = S_SQ_M;
      end
      S_SQ_M: begin
        cmd.op     = OP_SQ_M;
        state_next = S_SQ_W;
      end
      S_SQ_W: begin
        cmd.op = OP_SQ_W;
        if (last) begin
          idx_next   = 2'd0;
          state_next = S_MS_M;
        end else begin
          idx_next   = idx + 2'd1;
          state_next = sts.thrust_on ? S_THR_M1 : S_DIV_GO;
        end
      end
      S_MS_M: begin
        cmd.op     = OP_MS_M;
        state_next = S_CMP;
      end
      S_CMP: begin
        state_next = sts.clamp ? S_SQRT_GO : S_POS_M;
      end
      S_SQRT_GO: begin
        cmd.op     = OP_SQRT;
        state_next = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (!sts.sqrt_busy) begin
          state_next = S_CL_M;
        end
      end
      S_CL_M: begin
        cmd.op     = OP_CL_M;
        state_next = S_CL_GO;
      end
      S_CL_GO: begin
        cmd.op     = OP_DIV_CL;
        state_next = S_CL_WAIT;
      end
      S_CL_WAIT: begin
        if (!sts.div_busy) begin
          state_next = S_CL_W;
        end
      end
      S_CL_W: begin
        cmd.op = OP_CL_W;
        if (last) begin
          idx_next   = 2'd0;
          state_next = S_POS_M;
        end else begin
          idx_next   = idx + 2'd1;
          state_next = S_CL_M;
        end
      end
      S_POS_M: begin
        cmd.op     = OP_POS_M;
        state_next = S_POS_W;
      end
      S_POS_W: begin
        cmd.op = OP_POS_W;
        if (last) begin
          state_next = S_WRAP;
        end else begin
          idx_next   = idx + 2'd1;
          state_next = S_POS_M;
        end
      end
      S_WRAP: begin
        cmd.op     = OP_WRAP;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op     = OP_LOAD_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= 2'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// File: design/euler_motion_integrator_with_drag.sv
// ----------------------------------------------------------------------------
// euler_motion_integrator_with_drag
// Semi-implicit Euler integrator of one body with drag and a speed clamp.
// ----------------------------------------------------------------------------
// An add-force request is accepted in the idle state. An update is dominated
// by three passes through the divider for acceleration, and runs longer when
// the speed clamp engages (a square root and three more divides). A static
// update goes directly to the result. One request is worked at a time; the
// result register lets the next request enter while a result waits. Reset
// clears the body state and loads the register defaults.
module euler_motion_integrator_with_drag #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  emi_req_if.sink     req,
  emi_rsp_if.source   rsp
);
  import emi_pkg::*;

  emi_cmd_t cmd;
  emi_sts_t sts;

  emi_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_command (req.command),
    .req_ready   (req.ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  emi_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_command   (req.command),
    .req_vec_x     (req.vec_x),
    .req_vec_y     (req.vec_y),
    .req_vec_z     (req.vec_z),
    .req_time_step (req.time_step),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .rsp           (rsp)
  );

endmodule
